FILE: hdl/vnmf_pkg.sv
package vnmf_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int MAX_KERNEL = 7;

  localparam int HALF_MAX = MAX_KERNEL / 2;
  localparam int SIDE     = 2 * HALF_MAX + 1;
  localparam int ROWS     = SIDE + 1;
  localparam int WIN      = SIDE * SIDE;

  localparam int PIX_W  = 16;
  localparam int CFG_W  = 11;
  localparam int K_W    = 3;
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int Y_W    = $clog2(MAX_HEIGHT);
  localparam int ROW_W  = $clog2(MAX_HEIGHT + HALF_MAX + 1);
  localparam int RY_W   = ROW_W + 1;
  localparam int XW     = CFG_W + 1;
  localparam int LANE_W = $clog2(ROWS);
  localparam int HALF_W = $clog2(HALF_MAX + 1);
  localparam int THR_W  = $clog2(MAX_KERNEL * MAX_KERNEL / 2 + 1);
  localparam int CNT_W  = $clog2(WIN + 1);
  localparam int GRP_W  = $clog2(SIDE + 1);
  localparam int SIDX_W = $clog2(SIDE);
  localparam int ARR_W  = $clog2(MAX_WIDTH * MAX_HEIGHT + HALF_MAX * MAX_WIDTH + HALF_MAX + 1);

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [PIX_W-1:0] INVALID_CODE = 16'hFFF0;

  typedef enum logic [1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1,
    CFG_KERNEL = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [PIX_W-1:0]       px;
    logic                   store;
    logic [COL_W-1:0]       col;
    logic [LANE_W-1:0]      lane;
    logic signed [RY_W-1:0] ry;
    logic                   emit;
    logic [COL_W-1:0]       ex;
    logic [CFG_W-1:0]       w;
    logic [CFG_W-1:0]       h;
    logic [HALF_W-1:0]      half;
    logic [THR_W-1:0]       thr;
    logic                   last;
  } item_t;

  typedef struct packed {
    logic [WIN-1:0][PIX_W-1:0] vals;
    logic [WIN-1:0]            ok;
    logic [PIX_W-1:0]          center;
    logic [THR_W-1:0]          thr;
    logic                      last;
  } cand_t;

  function automatic logic [GRP_W-1:0] popcnt(input logic [SIDE-1:0] b);
    logic [GRP_W-1:0] s;
    s = '0;
    for (int i = 0; i < SIDE; i++) begin
      s = s + GRP_W'(b[i]);
    end
    return s;
  endfunction

endpackage

FILE: hdl/vnmf_front.sv
module vnmf_front import vnmf_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [15:0]      s_axis_tdata,  // [15:0] pixel
  input  logic             s_axis_tuser,  // [0] drain
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [1:0]       cfg_index_i,
  input  logic [CFG_W-1:0] cfg_data_i,
  input  logic             q_full_i,
  output logic             q_push_o,
  output item_t            q_item_o
);

  logic [CFG_W-1:0] cfg_w_q, cfg_h_q, cur_w_q, cur_h_q;
  logic [K_W-1:0]   cfg_k_q, cur_k_q;
  logic [ROW_W-1:0] row_q, row_d;
  logic [COL_W-1:0] col_q, col_d, ex_q, ex_d;
  logic [Y_W-1:0]   ey_q, ey_d;
  logic [ARR_W-1:0] arr_q, arr_d, dly;

  logic [CFG_W-1:0]   sat_w, sat_h, w_e, h_e;
  logic [K_W-1:0]     sat_k, k_e;
  logic [HALF_W-1:0]  half_e;
  logic [2*K_W-1:0]   ksq;
  logic               start, in_frame, emit, last, accept, drop;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_w_q <= CFG_W'(640);
      cfg_h_q <= CFG_W'(480);
      cfg_k_q <= K_W'(5);
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_WIDTH:  cfg_w_q <= cfg_data_i;
        CFG_HEIGHT: cfg_h_q <= cfg_data_i;
        CFG_KERNEL: cfg_k_q <= cfg_data_i[K_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    sat_w = (cfg_w_q == '0) ? CFG_W'(1) :
            (cfg_w_q > CFG_W'(MAX_WIDTH)) ? CFG_W'(MAX_WIDTH) : cfg_w_q;
    sat_h = (cfg_h_q == '0) ? CFG_W'(1) :
            (cfg_h_q > CFG_W'(MAX_HEIGHT)) ? CFG_W'(MAX_HEIGHT) : cfg_h_q;
    sat_k = (cfg_k_q > K_W'(MAX_KERNEL)) ? K_W'(MAX_KERNEL) : cfg_k_q;
    start = (row_q == '0) && (col_q == '0);
    w_e = start ? sat_w : cur_w_q;
    h_e = start ? sat_h : cur_h_q;
    k_e = start ? sat_k : cur_k_q;
    half_e = HALF_W'(k_e >> 1);
    ksq = {{K_W{1'b0}}, k_e} * {{K_W{1'b0}}, k_e};
    in_frame = CFG_W'(row_q) < h_e;
    // results start half*width+half items into the frame; half may exceed the width
    dly = ARR_W'({{CFG_W{1'b0}}, half_e} * {{HALF_W{1'b0}}, w_e}) + ARR_W'(half_e);
    emit = arr_q >= dly;
    last = emit && (CFG_W'(ex_q) == w_e - CFG_W'(1)) && (CFG_W'(ey_q) == h_e - CFG_W'(1));
    accept = s_axis_tvalid && s_axis_tready;
    drop = in_frame && s_axis_tuser;
  end

  assign s_axis_tready = !q_full_i;
  assign q_push_o      = accept && !drop;

  always_comb begin
    q_item_o.px    = s_axis_tdata;
    q_item_o.store = in_frame;
    q_item_o.col   = col_q;
    q_item_o.lane  = row_q[LANE_W-1:0];
    q_item_o.ry    = $signed({1'b0, row_q}) - $signed(RY_W'(half_e));
    q_item_o.emit  = emit;
    q_item_o.ex    = ex_q;
    q_item_o.w     = w_e;
    q_item_o.h     = h_e;
    q_item_o.half  = half_e;
    q_item_o.thr   = THR_W'(ksq >> 1);
    q_item_o.last  = last;
  end

  // advance arrival and emit positions; wrap both at the frame's last result
  always_comb begin
    row_d = row_q;
    col_d = col_q;
    ex_d  = ex_q;
    ey_d  = ey_q;
    arr_d = arr_q;
    if (q_push_o) begin
      if (last) begin
        row_d = '0;
        col_d = '0;
        ex_d  = '0;
        ey_d  = '0;
        arr_d = '0;
      end else begin
        arr_d = arr_q + ARR_W'(1);
        if (CFG_W'(col_q) == w_e - CFG_W'(1)) begin
          col_d = '0;
          row_d = row_q + ROW_W'(1);
        end else begin
          col_d = col_q + COL_W'(1);
        end
        if (emit) begin
          if (CFG_W'(ex_q) == w_e - CFG_W'(1)) begin
            ex_d = '0;
            ey_d = ey_q + Y_W'(1);
          end else begin
            ex_d = ex_q + COL_W'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q   <= '0;
      col_q   <= '0;
      ex_q    <= '0;
      ey_q    <= '0;
      arr_q   <= '0;
      cur_w_q <= CFG_W'(640);
      cur_h_q <= CFG_W'(480);
      cur_k_q <= K_W'(5);
    end else begin
      row_q <= row_d;
      col_q <= col_d;
      ex_q  <= ex_d;
      ey_q  <= ey_d;
      arr_q <= arr_d;
      if (accept && start) begin
        cur_w_q <= sat_w;
        cur_h_q <= sat_h;
        cur_k_q <= sat_k;
      end
    end
  end

endmodule

FILE: hdl/vnmf_queue.sv
module vnmf_queue import vnmf_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t item_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  valid_o,
  output item_t item_o
);

  item_t             slot_q [QDEPTH];
  logic [QPTR_W-1:0] wr_q, rd_q;
  logic [QCNT_W-1:0] cnt_q;

  assign full_o  = (cnt_q == QCNT_W'(QDEPTH));
  assign valid_o = (cnt_q != '0);
  assign item_o  = slot_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[wr_q] <= item_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + QPTR_W'(1);
      if (pop_i)  rd_q <= rd_q + QPTR_W'(1);
      cnt_q <= cnt_q + QCNT_W'(push_i) - QCNT_W'(pop_i);
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QCNT_W'(QDEPTH)) else $error("queue count overflow");
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |-> (cnt_q != QCNT_W'(QDEPTH))) else $error("push into full queue");
  a_no_underrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> (cnt_q != '0)) else $error("pop from empty queue");

endmodule

FILE: hdl/vnmf_window.sv
module vnmf_window import vnmf_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  adv_i,
  input  logic  q_valid_i,
  input  item_t q_item_i,
  output logic  q_pop_o,
  output logic  c_valid_o,
  output cand_t cand_o
);

  logic [ROWS-1:0][PIX_W-1:0] mem_q [MAX_WIDTH];
  logic [ROWS-1:0][PIX_W-1:0] rd_q;

  item_t s1_q, s2_q, s3_q;
  logic  s1_valid_q, s2_valid_q, s3_valid_q, c_valid_q;
  cand_t c_q, cand_d;

  logic [SIDE-1:0][SIDE-1:0][PIX_W-1:0] win_q;
  logic [SIDE-1:0][PIX_W-1:0]           col_d;
  logic signed [RY_W-1:0]               row_y [SIDE];
  logic [SIDE-1:0]                      row_in;
  logic [XW-1:0]                        pos [SIDE];
  logic [SIDE-1:0]                      okcol;
  logic [SIDX_W-1:0]                    cidx;

  assign q_pop_o = adv_i && q_valid_i;

  // write the new sample, then read its column once the item has moved into stage s1
  always_ff @(posedge clk_i) begin
    if (q_pop_o && q_item_i.store) mem_q[q_item_i.col][q_item_i.lane] <= q_item_i.px;
    if (adv_i) rd_q <= mem_q[s1_q.col];
  end

  // gather the column around its centre row, zero outside the frame or the kernel
  always_comb begin
    for (int r = 0; r < SIDE; r++) begin
      row_y[r] = s2_q.ry + RY_W'(r) - RY_W'(HALF_MAX);
      row_in[r] = (r + int'(s2_q.half) >= HALF_MAX) && (r <= HALF_MAX + int'(s2_q.half)) &&
                  !row_y[r][RY_W-1] && (row_y[r] < $signed({1'b0, s2_q.h}));
      col_d[r] = row_in[r] ? rd_q[row_y[r][LANE_W-1:0]] : '0;
    end
  end

  always_comb begin
    for (int j = 0; j < SIDE; j++) begin
      pos[j] = XW'(s3_q.ex) + XW'(j) + XW'(s3_q.half);
      okcol[j] = (j + 2 * int'(s3_q.half) >= SIDE - 1) && (pos[j] >= XW'(SIDE - 1)) &&
                 (pos[j] < XW'(s3_q.w) + XW'(SIDE - 1));
    end
    cidx = SIDX_W'(SIDE - 1) - SIDX_W'(s3_q.half);
    for (int j = 0; j < SIDE; j++) begin
      for (int r = 0; r < SIDE; r++) begin
        cand_d.vals[j*SIDE+r] = win_q[j][r];
        cand_d.ok[j*SIDE+r]   = okcol[j] && !win_q[j][r][PIX_W-1] && (win_q[j][r] != '0);
      end
    end
    cand_d.center = win_q[cidx][HALF_MAX];
    cand_d.thr    = s3_q.thr;
    cand_d.last   = s3_q.last;
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      s1_q <= q_item_i;
      s2_q <= s1_q;
      s3_q <= s2_q;
      c_q  <= cand_d;
      if (s2_valid_q) win_q <= {col_d, win_q[SIDE-1:1]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      c_valid_q  <= 1'b0;
    end else if (adv_i) begin
      s1_valid_q <= q_valid_i;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q && s2_q.emit;
      c_valid_q  <= s3_valid_q;
    end
  end

  assign c_valid_o = c_valid_q;
  assign cand_o    = c_q;

endmodule

FILE: hdl/vnmf_median.sv
module vnmf_median import vnmf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        c_valid_i,
  input  cand_t       cand_i,
  output logic        adv_o,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // [15:0] filtered
  output logic        m_axis_tlast   // last_of_frame
);

  logic [WIN-1:0][WIN-1:0] lt_d, lt_q;
  cand_t c5_q, c6_q, c7_q;
  logic  v5_q, v6_q, v7_q;

  logic [WIN-1:0][SIDE-1:0][GRP_W-1:0] grp_d, grp_q;
  logic [SIDE-1:0][GRP_W-1:0]          okg_d, okg_q;
  logic [CNT_W-1:0]                    cnt_d, cnt_q;
  logic [CNT_W-1:0]                    rank [WIN];
  logic [WIN-1:0]                      sel_d, sel_q;

  logic [PIX_W-1:0] med, res;
  logic             out_valid_q, out_last_q;
  logic [PIX_W-1:0] out_data_q;

  assign adv_o = !out_valid_q || m_axis_tready;

  // rank order with ties broken by window position
  always_comb begin
    for (int i = 0; i < WIN; i++) begin
      for (int j = 0; j < WIN; j++) begin
        lt_d[i][j] = cand_i.ok[j] &&
                     (($signed(cand_i.vals[j]) < $signed(cand_i.vals[i])) ||
                      ((cand_i.vals[j] == cand_i.vals[i]) && (j < i)));
      end
    end
  end

  always_comb begin
    for (int i = 0; i < WIN; i++) begin
      for (int g = 0; g < SIDE; g++) begin
        grp_d[i][g] = popcnt(lt_q[i][g*SIDE +: SIDE]);
      end
    end
    for (int g = 0; g < SIDE; g++) begin
      okg_d[g] = popcnt(c5_q.ok[g*SIDE +: SIDE]);
    end
  end

  always_comb begin
    cnt_d = '0;
    for (int g = 0; g < SIDE; g++) begin
      cnt_d = cnt_d + CNT_W'(okg_q[g]);
    end
    for (int i = 0; i < WIN; i++) begin
      rank[i] = '0;
      for (int g = 0; g < SIDE; g++) begin
        rank[i] = rank[i] + CNT_W'(grp_q[i][g]);
      end
      sel_d[i] = c6_q.ok[i] && (rank[i] == (cnt_d >> 1));
    end
  end

  always_comb begin
    med = '0;
    for (int i = 0; i < WIN; i++) begin
      med = med | (c7_q.vals[i] & {PIX_W{sel_q[i]}});
    end
    if ($signed(c7_q.center) <= 0) begin
      res = c7_q.center;
    end else if (cnt_q < CNT_W'(c7_q.thr)) begin
      res = INVALID_CODE;
    end else begin
      res = med;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_o) begin
      lt_q  <= lt_d;
      c5_q  <= cand_i;
      grp_q <= grp_d;
      okg_q <= okg_d;
      c6_q  <= c5_q;
      sel_q <= sel_d;
      cnt_q <= cnt_d;
      c7_q  <= c6_q;
      out_data_q <= res;
      out_last_q <= c7_q.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
      v6_q <= 1'b0;
      v7_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv_o) begin
      v5_q <= c_valid_i;
      v6_q <= v5_q;
      v7_q <= v6_q;
      out_valid_q <= v7_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

  a_one_median: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v7_q && (cnt_q != '0)) |-> $onehot(sel_q)) else $error("median select not one-hot");

endmodule

FILE: hdl/valid_neighbor_median_filter.sv
// Masked median filter for a raster stream of signed Q12.4 disparity pixels. One item is
// taken per clock while the 4-entry queue between the front end and the filter pipeline
// has room; sustained rate is one item per cycle while the output is not stalled, limited
// by the single write and read port of the line store (1024 columns x 8 rows of 16 bits,
// one column word per address). The result for a centre leaves on the input item
// half*width+half positions later, after the window and median pipeline registers; drain
// items (tuser high) after the frame flush the trailing results and are dropped while the
// frame is still arriving. Width, height and kernel are taken at the first item of a frame;
// write them only between frames. The line store needs no clearing after reset.
module valid_neighbor_median_filter import vnmf_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [15:0]      s_axis_tdata,  // [15:0] pixel
  input  logic             s_axis_tuser,  // [0] drain
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [15:0]      m_axis_tdata,  // [15:0] filtered
  output logic             m_axis_tlast,  // last_of_frame
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [1:0]       cfg_index_i,
  input  logic [CFG_W-1:0] cfg_data_i
);

  logic  q_push, q_full, q_pop, q_valid, c_valid, adv;
  item_t q_in, q_out;
  cand_t cand;

  vnmf_front u_front (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .q_full_i (q_full),
    .q_push_o (q_push),
    .q_item_o (q_in)
  );

  vnmf_queue u_queue (
    .clk_i, .rst_ni,
    .push_i  (q_push),
    .item_i  (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .item_o  (q_out)
  );

  vnmf_window u_window (
    .clk_i, .rst_ni,
    .adv_i     (adv),
    .q_valid_i (q_valid),
    .q_item_i  (q_out),
    .q_pop_o   (q_pop),
    .c_valid_o (c_valid),
    .cand_o    (cand)
  );

  vnmf_median u_median (
    .clk_i, .rst_ni,
    .c_valid_i (c_valid),
    .cand_i    (cand),
    .adv_o     (adv),
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast
  );

endmodule

FILE: tb/tb_valid_neighbor_median_filter.sv
`timescale 1ns / 1ps

module tb_valid_neighbor_median_filter;
  import vnmf_pkg::*;

  class median_scoreboard;
    logic [PIX_W-1:0] rows_mem [ROWS*MAX_WIDTH];
    int unsigned reg_w = 640, reg_h = 480, reg_k = 5;
    int unsigned fr_w = 640, fr_h = 480, fr_k = 5;
    int unsigned arrivals, emits;
    logic [16:0] expected_q[$];  // {last, filtered}
    int errors;

    function void load_reg(cfg_idx_e idx, logic [CFG_W-1:0] val);
      case (idx)
        CFG_WIDTH:  reg_w = val;
        CFG_HEIGHT: reg_h = val;
        CFG_KERNEL: reg_k = val[K_W-1:0];
        default: ;
      endcase
    endfunction

    function int to_int(logic [PIX_W-1:0] v);
      return int'($signed(v));
    endfunction

    function logic [PIX_W-1:0] median_at(int unsigned c);
      int vals[$];
      int y, x, half, yy, xx, v;
      logic [PIX_W-1:0] centre;
      y = c / fr_w;
      x = c % fr_w;
      half = fr_k / 2;
      centre = rows_mem[(y % ROWS) * MAX_WIDTH + x];
      if (to_int(centre) <= 0) return centre;
      for (yy = y - half; yy <= y + half; yy++) begin
        if (yy < 0 || yy >= int'(fr_h)) continue;
        for (xx = x - half; xx <= x + half; xx++) begin
          if (xx < 0 || xx >= int'(fr_w)) continue;
          v = to_int(rows_mem[(yy % ROWS) * MAX_WIDTH + xx]);
          if (v > 0) vals.push_back(v);
        end
      end
      if (vals.size() < (fr_k * fr_k) / 2) return INVALID_CODE;
      vals.sort();
      return PIX_W'(vals[vals.size() / 2]);
    endfunction

    function void note_pixel(logic [PIX_W-1:0] px, logic drain);
      int unsigned n, d, t;
      logic is_last;
      if (arrivals == 0) begin
        fr_w = (reg_w == 0) ? 1 : (reg_w > MAX_WIDTH ? MAX_WIDTH : reg_w);
        fr_h = (reg_h == 0) ? 1 : (reg_h > MAX_HEIGHT ? MAX_HEIGHT : reg_h);
        fr_k = (reg_k > MAX_KERNEL) ? MAX_KERNEL : reg_k;
      end
      n = fr_w * fr_h;
      d = (fr_k / 2) * fr_w + fr_k / 2;
      t = arrivals;
      if (t < n) begin
        if (drain) return;  // drop early drain
        rows_mem[((t / fr_w) % ROWS) * MAX_WIDTH + (t % fr_w)] = px;
      end
      arrivals = t + 1;
      if (t < d) return;
      is_last = (emits == n - 1);
      expected_q.push_back({is_last, median_at(emits)});
      if (is_last) begin
        arrivals = 0;
        emits = 0;
      end else begin
        emits++;
      end
    endfunction

    function void check_result(logic [PIX_W-1:0] data, logic last);
      logic [16:0] exp_r;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result filtered=%0d last=%0b", $time,
                 $signed(data), last);
        errors++;
        return;
      end
      exp_r = expected_q.pop_front();
      if (exp_r[15:0] !== data) begin
        $display("%0t: filtered mismatch expected %0d actual %0d", $time,
                 $signed(exp_r[15:0]), $signed(data));
        errors++;
      end
      if (exp_r[16] !== last) begin
        $display("%0t: tlast mismatch expected %0b actual %0b", $time, exp_r[16], last);
        errors++;
      end
    endfunction
  endclass

  logic             clk_i;
  logic             rst_ni;
  logic             s_axis_tvalid;
  logic             s_axis_tready;
  logic [15:0]      s_axis_tdata;
  logic             s_axis_tuser;
  logic             m_axis_tvalid;
  logic             m_axis_tready;
  logic [15:0]      m_axis_tdata;
  logic             m_axis_tlast;
  logic             cfg_valid_i;
  logic             cfg_ready_o;
  logic [1:0]       cfg_index_i;
  logic [CFG_W-1:0] cfg_data_i;

  valid_neighbor_median_filter u_top (.*);

  median_scoreboard sb = new();
  int burst_left;
  int items_sent;
  int valid_pct;
  int stall_pct;
  int idle_cycles;
  bit valid_hi;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // receiver stalls: stall rate is picked anew at random moments
  always @(posedge clk_i) begin
    if (($urandom_range(0, 255)) == 0) begin
      case ($urandom_range(0, 3))
        0: stall_pct <= 0;
        1: stall_pct <= 25;
        2: stall_pct <= 60;
        default: stall_pct <= 90;
      endcase
    end
    m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
  end

  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata, m_axis_tlast);
  end

  // watchdog: count cycles with no request moving on any channel
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= 4000) begin
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_request(logic [15:0] px, logic drain);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= px;
    s_axis_tuser  <= drain;
    valid_hi = 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_pixel(px, drain);
    items_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      s_axis_tvalid <= 1'b0;
      valid_hi = 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 40);
    end
  endtask

  // hold until every expected result has arrived, then let the pipeline settle
  task automatic wait_drained();
    if (valid_hi) begin
      s_axis_tvalid <= 1'b0;
      valid_hi = 1'b0;
    end
    @(posedge clk_i);
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_regs(logic [CFG_W-1:0] w, logic [CFG_W-1:0] h, logic [CFG_W-1:0] k);
    cfg_idx_e idx;
    logic [CFG_W-1:0] vals [3];
    vals = '{w, h, k};
    cfg_valid_i <= 1'b1;
    for (int i = 0; i < 3; i++) begin
      idx = cfg_idx_e'(i);
      cfg_index_i <= idx;
      cfg_data_i  <= vals[i];
      @(posedge clk_i);
      while (!cfg_ready_o) @(posedge clk_i);
      sb.load_reg(idx, vals[i]);
    end
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [15:0] pick_pixel();
    if ($urandom_range(0, 99) < valid_pct) begin
      return ($urandom_range(0, 9) == 0) ? 16'($urandom_range(1, 32767))
                                         : 16'($urandom_range(1, 400));
    end
    case ($urandom_range(0, 3))
      0: return 16'd0;
      1: return 16'($urandom_range(32768, 65535));
      2: return ($urandom_range(0, 1)) ? 16'h8000 : 16'hFFFF;
      default: return 16'($urandom());
    endcase
  endfunction

  // one frame plus its flush, with occasional stray drains and pixels
  task automatic run_frame(int unsigned w, int unsigned h, int unsigned k, bit noise);
    int unsigned fw, fh, fk, n, d;
    fw = (w == 0) ? 1 : (w > MAX_WIDTH ? MAX_WIDTH : w);
    fh = (h == 0) ? 1 : (h > MAX_HEIGHT ? MAX_HEIGHT : h);
    fk = (k > MAX_KERNEL) ? MAX_KERNEL : k;
    n = fw * fh;
    d = (fk / 2) * fw + fk / 2;
    write_regs(CFG_W'(w), CFG_W'(h), CFG_W'(k));
    for (int unsigned t = 0; t < n; t++) begin
      if (noise && $urandom_range(0, 19) == 0) send_request(16'($urandom()), 1'b1);
      send_request(pick_pixel(), 1'b0);
    end
    for (int unsigned t = 0; t < d; t++) begin
      if (noise && $urandom_range(0, 9) == 0) send_request(16'($urandom()), 1'b0);
      else send_request(16'($urandom()), 1'b1);
    end
    wait_drained();
  endtask

  initial begin
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= 1'b0;
    cfg_valid_i   <= 1'b0;
    cfg_index_i   <= CFG_WIDTH;
    cfg_data_i    <= '0;
    m_axis_tready <= 1'b0;
    stall_pct     = 0;
    idle_cycles   = 0;
    burst_left    = 10;
    valid_hi      = 1'b0;
    items_sent    = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: tiny frames, oversize and zero sizes, kernel extremes, even kernels,
    // windows wider than the frame
    valid_pct = 80;
    run_frame(1, 1, 0, 0);
    run_frame(0, 0, 1, 0);
    run_frame(3, 3, 7, 0);
    run_frame(4, 3, 2, 0);
    valid_pct = 100;
    run_frame(3, 2, 3, 0);
    valid_pct = 50;
    run_frame(5, 4, 6, 1);
    run_frame(2047, 1, 1, 0);
    run_frame(1, 12, 4, 0);
    run_frame(2, 9, 7, 0);

    while (items_sent < 1800) begin
      case ($urandom_range(0, 2))
        0: valid_pct = 20;
        1: valid_pct = 60;
        default: valid_pct = 95;
      endcase
      run_frame($urandom_range(1, 16), $urandom_range(1, 12), $urandom_range(0, 7), 1);
    end

    wait_drained();
    repeat (30) @(posedge clk_i);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
